// ===== src/rvb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stereo feedback comb reverb.
// Used by every module of the block; depends on nothing.
package rvb_pkg;

   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SAMPLE_W    = 16;
   localparam int WET_W       = 24;
   localparam int GAIN_W      = 16;
   localparam int LEN_W       = 17;
   localparam int COUNT_W     = 24;
   localparam int POS_CMP_W   = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;
   localparam int PROD_W      = WET_W + GAIN_W + 1;
   localparam int SUM_W       = PROD_W - 15 + 1;

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [GAIN_W-1:0]  GAIN_RESET    = GAIN_W'(16384);
   localparam logic [LEN_W-1:0]   LENGTH_RESET  = LEN_W'(44100);
   localparam logic [COUNT_W-1:0] HOLDOFF_RESET = COUNT_W'(44100);
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

   typedef enum logic [1:0] {
      REG_GAIN    = 2'd0,
      REG_LENGTH  = 2'd1,
      REG_HOLDOFF = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [WET_W-1:0] left_wet;
      logic signed [WET_W-1:0] right_wet;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  feedback_gain;
      logic [LEN_W-1:0]   loop_length;
      logic [COUNT_W-1:0] holdoff_samples;
   } cfg_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] cnt;
   } fifo_stat_type;

endpackage

// ===== src/stereo_feedback_comb_reverb_core.sv =====
`timescale 1ns / 1ps
// Top level of the stereo feedback comb reverb: loop memory, position, pipeline.
// Depends on rvb_pkg, rvb_csr, rvb_comb_lane and rvb_out_fifo.
//
// Takes one stereo pair per clock while req_ready is high, and returns one wet pair per
// pair, in order. Both channels share one loop memory of STORE_DEPTH rows (65536), each
// row holding the left and right 24-bit entries; a row is read when the pair is taken,
// multiplied by the feedback gain in stage 1 and written back from stage 2, and the wet
// pair is pushed into the result queue from stage 1. An item whose loop position equals
// that of the non-held item in stage 1 (loop length 0 or 1) waits for that write; all
// other hazards are forwarded, so the rate is one pair per cycle otherwise, including
// during the holdoff. After reset the memory is cleared one row per cycle, during which
// req_ready is low and the configuration port is available. A four-entry result queue
// absorbs rsp_ready stalls; req_ready drops when it cannot take another result.
module stereo_feedback_comb_reverb_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rvb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rvb_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rvb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rvb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rvb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int ROW_W = 2 * rvb_pkg::WET_W;

   rvb_pkg::cfg_type       cfg;
   rvb_pkg::fifo_stat_type fifo_stat;
   rvb_pkg::rsp_type       push_data;

   logic [ROW_W-1:0] loop_mem [rvb_pkg::STORE_DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   logic                        clr_active_ff, clr_active_in;
   logic [rvb_pkg::ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   logic [rvb_pkg::ADDR_W-1:0]  pos_ff, pos_in;
   logic [rvb_pkg::COUNT_W-1:0] seen_ff, seen_in;
   logic [rvb_pkg::ADDR_W:0]    pos_nxt;
   logic                        pos_wrap;
   logic                        held_new;
   logic                        accept;
   logic                        hazard;
   logic                        room;

   logic                               s1_v_ff;
   logic                               s1_held_ff;
   logic [rvb_pkg::ADDR_W-1:0]         s1_addr_ff;
   rvb_pkg::req_type                   s1_req_ff;
   logic                               s2_v_ff;
   logic                               s2_held_ff;
   logic [rvb_pkg::ADDR_W-1:0]         s2_addr_ff;

   logic                               wb_v_ff;
   logic [rvb_pkg::ADDR_W-1:0]         wb_addr_ff;
   logic [ROW_W-1:0]                   wb_data_ff;

   logic                               fwd_zero;
   logic                               fwd_wb;
   logic [ROW_W-1:0]                   entry_row;
   logic signed [rvb_pkg::WET_W-1:0]   left_entry, right_entry;
   logic signed [rvb_pkg::WET_W-1:0]   left_wr, right_wr;

   logic                               mem_we;
   logic [rvb_pkg::ADDR_W-1:0]         mem_waddr;
   logic [ROW_W-1:0]                   mem_wdata;

   rvb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---- clearing pass ----
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == rvb_pkg::ADDR_W'(rvb_pkg::STORE_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // ---- accept, position and counter ----
   assign room     = (32'(fifo_stat.cnt) + 32'(s1_v_ff)) < rvb_pkg::FIFO_DEPTH;
   assign hazard   = s1_v_ff && !s1_held_ff && (s1_addr_ff == pos_ff);
   assign req_ready = !clr_active_ff && room && !hazard;
   assign accept   = req_valid && req_ready;
   assign held_new = seen_ff < cfg.holdoff_samples;

   assign pos_nxt  = {1'b0, pos_ff} + 1'b1;
   assign pos_wrap = ((rvb_pkg::POS_CMP_W)'(pos_nxt) >= (rvb_pkg::POS_CMP_W)'(cfg.loop_length))
                     || ((rvb_pkg::POS_CMP_W)'(pos_nxt)
                         >= (rvb_pkg::POS_CMP_W)'(rvb_pkg::STORE_DEPTH));

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (seen_ff != rvb_pkg::COUNT_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
         if (!held_new) begin
            pos_in = pos_wrap ? '0 : pos_nxt[rvb_pkg::ADDR_W-1:0];
         end
      end
   end

   // ---- loop memory ----
   assign mem_we    = clr_active_ff || s2_v_ff;
   assign mem_waddr = clr_active_ff ? clr_addr_ff : s2_addr_ff;
   assign mem_wdata = clr_active_ff ? '0 : {left_wr, right_wr};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         loop_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= loop_mem[pos_ff];
   end

   // ---- stage 1: entry select with forwarding ----
   assign fwd_zero  = s2_v_ff && s2_held_ff && (s2_addr_ff == s1_addr_ff);
   assign fwd_wb    = wb_v_ff && (wb_addr_ff == s1_addr_ff);
   assign entry_row = fwd_zero ? '0 : (fwd_wb ? wb_data_ff : rd_data_ff);
   assign left_entry  = entry_row[ROW_W-1:rvb_pkg::WET_W];
   assign right_entry = entry_row[rvb_pkg::WET_W-1:0];

   assign push_data.left_wet  = s1_held_ff ? '0 : left_entry;
   assign push_data.right_wet = s1_held_ff ? '0 : right_entry;

   rvb_comb_lane u_left (
      .clock    (clock),
      .entry    (left_entry),
      .gain     (cfg.feedback_gain),
      .sample   (s1_req_ff.left_sample),
      .held     (s1_held_ff),
      .wr_value (left_wr)
   );

   rvb_comb_lane u_right (
      .clock    (clock),
      .entry    (right_entry),
      .gain     (cfg.feedback_gain),
      .sample   (s1_req_ff.right_sample),
      .held     (s1_held_ff),
      .wr_value (right_wr)
   );

   rvb_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_v_ff),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .stat      (fifo_stat)
   );

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      s1_addr_ff <= pos_ff;
      s1_held_ff <= held_new;
      s1_req_ff  <= req_data;
      s2_addr_ff <= s1_addr_ff;
      s2_held_ff <= s1_held_ff;
      wb_addr_ff <= mem_waddr;
      wb_data_ff <= mem_wdata;
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         pos_ff        <= '0;
         seen_ff       <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         wb_v_ff       <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         pos_ff        <= pos_in;
         seen_ff       <= seen_in;
         s1_v_ff       <= accept;
         s2_v_ff       <= s1_v_ff;
         wb_v_ff       <= mem_we;
      end
   end

   // ---- assertions ----
   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !clr_active_ff)
      else $error("transfer accepted during clearing pass");

   a_no_unforwarded_overlap: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff && !s2_held_ff |-> s1_addr_ff != s2_addr_ff)
      else $error("read-modify-write overlap on one row");

   a_fifo_room_on_push: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> 32'(fifo_stat.cnt) < rvb_pkg::FIFO_DEPTH)
      else $error("result queue overflow");

   a_held_keeps_position: assert property (@(posedge clock) disable iff (reset)
      accept && held_new |=> pos_ff == $past(pos_ff))
      else $error("position moved on a held transfer");

endmodule

// ===== src/rvb_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port.
// Depends on rvb_pkg for the register map and the cfg_type bundle.
module rvb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rvb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rvb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rvb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output rvb_pkg::cfg_type               cfg
);

   rvb_pkg::cfg_type      cfg_ff, cfg_in;
   rvb_pkg::reg_index_type reg_sel;
   logic                  wr_en;

   assign reg_sel = rvb_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            rvb_pkg::REG_GAIN:    cfg_in.feedback_gain   = pwdata[rvb_pkg::GAIN_W-1:0];
            rvb_pkg::REG_LENGTH:  cfg_in.loop_length     = pwdata[rvb_pkg::LEN_W-1:0];
            rvb_pkg::REG_HOLDOFF: cfg_in.holdoff_samples = pwdata[rvb_pkg::COUNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         rvb_pkg::REG_GAIN:    prdata = rvb_pkg::CSR_DATA_W'(cfg_ff.feedback_gain);
         rvb_pkg::REG_LENGTH:  prdata = rvb_pkg::CSR_DATA_W'(cfg_ff.loop_length);
         rvb_pkg::REG_HOLDOFF: prdata = rvb_pkg::CSR_DATA_W'(cfg_ff.holdoff_samples);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feedback_gain   <= rvb_pkg::GAIN_RESET;
         cfg_ff.loop_length     <= rvb_pkg::LENGTH_RESET;
         cfg_ff.holdoff_samples <= rvb_pkg::HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/rvb_comb_lane.sv =====
`timescale 1ns / 1ps
// One channel of the comb update: registered Q1.15 product, then add and saturate.
// Depends on rvb_pkg for widths.
module rvb_comb_lane (
   input  logic                                clock,
   input  logic signed [rvb_pkg::WET_W-1:0]    entry,
   input  logic        [rvb_pkg::GAIN_W-1:0]   gain,
   input  logic signed [rvb_pkg::SAMPLE_W-1:0] sample,
   input  logic                                held,
   output logic signed [rvb_pkg::WET_W-1:0]    wr_value
);

   logic signed [rvb_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [rvb_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                held_ff;
   logic signed [rvb_pkg::SUM_W-1:0]    scaled;
   logic signed [rvb_pkg::SUM_W-1:0]    sum;
   logic                                ovf;

   assign prod_in = entry * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      sample_ff <= sample;
      held_ff   <= held;
   end

   // floor shift by 15
   assign scaled = $signed({prod_ff[rvb_pkg::PROD_W-1], prod_ff[rvb_pkg::PROD_W-1:15]});
   assign sum    = scaled + rvb_pkg::SUM_W'(sample_ff);
   assign ovf    = (sum[rvb_pkg::SUM_W-1:rvb_pkg::WET_W-1] != '0) &&
                   (sum[rvb_pkg::SUM_W-1:rvb_pkg::WET_W-1] != '1);

   always_comb begin
      if (held_ff) begin
         wr_value = '0;
      end else if (ovf) begin
         wr_value = sum[rvb_pkg::SUM_W-1] ? {1'b1, {(rvb_pkg::WET_W-1){1'b0}}}
                                          : {1'b0, {(rvb_pkg::WET_W-1){1'b1}}};
      end else begin
         wr_value = sum[rvb_pkg::WET_W-1:0];
      end
   end

endmodule

// ===== src/rvb_out_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the loop pipeline and the rsp channel.
// Depends on rvb_pkg for rsp_type and the fill status bundle.
module rvb_out_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rvb_pkg::rsp_type        push_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rvb_pkg::rsp_type        rsp_data,
   output rvb_pkg::fifo_stat_type  stat
);

   rvb_pkg::rsp_type                slot_ff [rvb_pkg::FIFO_DEPTH];
   logic [rvb_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [rvb_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [rvb_pkg::FIFO_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign stat.cnt  = cnt_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
